/* design/gga_pkg.sv */
// Shared constants, types and helper functions for the GGA field extractor.
// Depends on nothing; the design files but gga_ifs use it by scoped name.
package gga_pkg;

	localparam int LINE_CAP  = 128;
	localparam int TEXT_CAP  = 15;
	localparam int NSLOT     = 4;
	localparam int LEN_W     = $clog2(LINE_CAP);
	localparam int TLEN_W    = $clog2(TEXT_CAP + 1);
	localparam int MEM_DEPTH = NSLOT * TEXT_CAP;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);
	localparam int FNUM_W    = 5;
	localparam logic [FNUM_W-1:0] FIELD_SAT = 5'd31;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] NUM_MAX  = 8'hFF;

	// "$GPGGA"
	localparam logic [7:0] GGA_PREFIX [6] = '{8'h24, 8'h47, 8'h50, 8'h47, 8'h47, 8'h41};
	localparam int PREFIX_LEN = 6;

	// Field numbers (comma counts) that carry data
	localparam logic [FNUM_W-1:0] FN_TIME = 5'd1;
	localparam logic [FNUM_W-1:0] FN_LAT  = 5'd2;
	localparam logic [FNUM_W-1:0] FN_LATD = 5'd3;
	localparam logic [FNUM_W-1:0] FN_LON  = 5'd4;
	localparam logic [FNUM_W-1:0] FN_LOND = 5'd5;
	localparam logic [FNUM_W-1:0] FN_FIX  = 5'd6;
	localparam logic [FNUM_W-1:0] FN_SATS = 5'd7;
	localparam logic [FNUM_W-1:0] FN_ALT  = 5'd9;

	typedef enum logic [2:0] {
		FC_TIME = 3'd0,
		FC_LAT  = 3'd1,
		FC_LATD = 3'd2,
		FC_LON  = 3'd3,
		FC_LOND = 3'd4,
		FC_FIX  = 3'd5,
		FC_SATS = 3'd6,
		FC_ALT  = 3'd7
	} field_code_t;

	typedef enum logic [1:0] {
		NP_LEAD   = 2'd0,
		NP_DIGITS = 2'd1,
		NP_NEG    = 2'd2,
		NP_DONE   = 2'd3
	} num_phase_t;

	typedef enum logic {
		FS_IDLE,
		FS_PROC
	} front_state_t;

	typedef enum logic {
		BS_IDLE,
		BS_RUN
	} back_state_t;

	typedef struct packed {
		num_phase_t phase;
		logic [7:0] val;
	} num_st_t;

	// Write into the text memory
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} text_wr_t;

	// Snapshot of a matched line handed to the back end
	typedef struct packed {
		logic                           start;
		logic [NSLOT-1:0][TLEN_W-1:0]   lens;
		logic [1:0][7:0]                dirs;
		logic [1:0][7:0]                nums;
	} job_t;

	typedef struct packed {
		field_code_t code;
		logic [7:0]  value;
		logic        last;
	} item_t;

	// One step of the decimal parse
	function automatic num_st_t num_step(num_st_t st, logic [7:0] c);
		num_st_t    r;
		logic       dig;
		logic [11:0] v;
		r   = st;
		dig = (c >= CH_ZERO) && (c <= CH_NINE);
		v   = 12'(st.val) * 12'd10 + 12'(c - CH_ZERO);
		unique case (st.phase)
			NP_LEAD: begin
				if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
					r = st;
				end else if (c == CH_PLUS) begin
					r.phase = NP_DIGITS;
				end else if (c == CH_MINUS) begin
					r.phase = NP_NEG;
				end else if (dig) begin
					r.val   = c - CH_ZERO;
					r.phase = NP_DIGITS;
				end else begin
					r.phase = NP_DONE;
				end
			end
			NP_DIGITS: begin
				if (!dig) begin
					r.phase = NP_DONE;
				end else begin
					r.val = (v > 12'(NUM_MAX)) ? NUM_MAX : v[7:0];
				end
			end
			default: r = st;
		endcase
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] text_addr(logic [1:0] slot, logic [TLEN_W-1:0] idx);
		logic [ADDR_W+2:0] a;
		a = (ADDR_W+3)'(slot) * (ADDR_W+3)'(TEXT_CAP) + (ADDR_W+3)'(idx);
		return a[ADDR_W-1:0];
	endfunction

endpackage

/* design/gga_ifs.sv */
// Valid/ready channel interfaces: received bytes in, result items out.
// Depends on nothing.
interface gga_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface gga_item_if;
	logic       valid;
	logic       ready;
	logic [2:0] field_code;
	logic [7:0] value;
	logic       last;
	modport source (output valid, output field_code, output value, output last, input ready);
	modport sink   (input valid, input field_code, input value, input last, output ready);
endinterface

/* design/gga_front.sv */
// Front end: takes bytes, tracks the line and splits GGA content on commas.
// Depends on gga_pkg and gga_byte_if; feeds text writes and jobs to gga_back.
module gga_front (
	input  logic              clk,
	input  logic              arst_n,
	gga_byte_if.sink          in_ch,
	input  logic              back_busy,
	output gga_pkg::text_wr_t text_wr,
	output gga_pkg::job_t     job
);

	gga_pkg::front_state_t state_q, state_d;
	logic [7:0]                  byte_q;
	logic [gga_pkg::LEN_W-1:0]   len_q, len_d;
	logic [gga_pkg::FNUM_W-1:0]  fnum_q, fnum_d;
	logic                        prefix_q, prefix_d;
	logic                        zero_q, zero_d;
	logic                        pend_q, pend_d;
	logic [gga_pkg::NSLOT-1:0][gga_pkg::TLEN_W-1:0] tlen_q, tlen_d;
	logic [1:0][7:0]             dir_q, dir_d;
	gga_pkg::num_st_t            num_q [2];
	gga_pkg::num_st_t            num_d [2];

	logic                        accept;
	logic                        do_c;
	logic [7:0]                  cc;
	logic [gga_pkg::LEN_W-1:0]   pos;
	logic [gga_pkg::LEN_W-1:0]   len_adj;
	logic                        clear;
	logic                        ok;
	logic                        tadd;
	logic [1:0]                  tslot;
	logic                        nadd;
	logic                        nslot;

	assign in_ch.ready = (state_q == gga_pkg::FS_IDLE) && !back_busy;
	assign accept      = in_ch.valid && in_ch.ready;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gga_pkg::FS_IDLE: if (accept) state_d = gga_pkg::FS_PROC;
			gga_pkg::FS_PROC: begin
				if (byte_q == gga_pkg::CH_LF || !pend_q) state_d = gga_pkg::FS_IDLE;
			end
			default: state_d = gga_pkg::FS_IDLE;
		endcase
	end

	// Line control: newline, pending carriage return, length limit
	always_comb begin
		len_d   = len_q;
		pend_d  = pend_q;
		clear   = 1'b0;
		do_c    = 1'b0;
		cc      = byte_q;
		pos     = len_q;
		len_adj = len_q;
		job       = '0;
		job.lens  = tlen_q;
		job.dirs  = dir_q;
		job.nums  = {num_q[1].val, num_q[0].val};
		if (state_q == gga_pkg::FS_PROC) begin
			if (byte_q == gga_pkg::CH_LF) begin
				if (pend_q && len_q != '0) len_adj = len_q - gga_pkg::LEN_W'(1);
				job.start = prefix_q &&
					(zero_q || len_adj >= gga_pkg::LEN_W'(gga_pkg::PREFIX_LEN));
				clear = 1'b1;
			end else if (pend_q) begin
				// deferred carriage return becomes content
				pend_d = 1'b0;
				do_c   = 1'b1;
				cc     = gga_pkg::CH_CR;
				pos    = len_q - gga_pkg::LEN_W'(1);
			end else if (len_q < gga_pkg::LEN_W'(gga_pkg::LINE_CAP - 1)) begin
				len_d = len_q + gga_pkg::LEN_W'(1);
				if (byte_q == gga_pkg::CH_CR) pend_d = 1'b1;
				else do_c = 1'b1;
			end else begin
				clear = 1'b1;
			end
		end
	end

	// Content handling
	always_comb begin
		zero_d   = zero_q;
		prefix_d = prefix_q;
		fnum_d   = fnum_q;
		tlen_d   = tlen_q;
		dir_d    = dir_q;
		num_d    = num_q;
		ok       = 1'b0;
		tadd     = 1'b0;
		tslot    = 2'd0;
		nadd     = 1'b0;
		nslot    = 1'b0;
		text_wr  = '0;
		if (do_c && !zero_q) begin
			if (cc == gga_pkg::CH_NUL) begin
				zero_d = 1'b1;
				if (pos < gga_pkg::LEN_W'(gga_pkg::PREFIX_LEN)) prefix_d = 1'b0;
			end else begin
				if (pos < gga_pkg::LEN_W'(gga_pkg::PREFIX_LEN)) begin
					ok       = (cc == gga_pkg::GGA_PREFIX[pos[2:0]]);
					prefix_d = (pos == '0) ? ok : (prefix_q && ok);
				end
				if (cc == gga_pkg::CH_COMMA) begin
					if (fnum_q < gga_pkg::FIELD_SAT) fnum_d = fnum_q + gga_pkg::FNUM_W'(1);
				end else begin
					unique case (fnum_q)
						gga_pkg::FN_TIME: begin tadd = 1'b1; tslot = 2'd0; end
						gga_pkg::FN_LAT:  begin tadd = 1'b1; tslot = 2'd1; end
						gga_pkg::FN_LATD: if (dir_q[0] == 8'd0) dir_d[0] = cc;
						gga_pkg::FN_LON:  begin tadd = 1'b1; tslot = 2'd2; end
						gga_pkg::FN_LOND: if (dir_q[1] == 8'd0) dir_d[1] = cc;
						gga_pkg::FN_FIX:  begin nadd = 1'b1; nslot = 1'b0; end
						gga_pkg::FN_SATS: begin nadd = 1'b1; nslot = 1'b1; end
						gga_pkg::FN_ALT:  begin tadd = 1'b1; tslot = 2'd3; end
						default: ;
					endcase
				end
			end
		end
		if (tadd && tlen_q[tslot] < gga_pkg::TLEN_W'(gga_pkg::TEXT_CAP)) begin
			text_wr.we    = 1'b1;
			text_wr.addr  = gga_pkg::text_addr(tslot, tlen_q[tslot]);
			text_wr.data  = cc;
			tlen_d[tslot] = tlen_q[tslot] + gga_pkg::TLEN_W'(1);
		end
		if (nadd) num_d[nslot] = gga_pkg::num_step(num_q[nslot], cc);
	end

	// Registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= gga_pkg::FS_IDLE;
			len_q    <= '0;
			fnum_q   <= '0;
			prefix_q <= 1'b0;
			zero_q   <= 1'b0;
			pend_q   <= 1'b0;
			tlen_q   <= '0;
			dir_q    <= '0;
			num_q[0] <= '{phase: gga_pkg::NP_LEAD, val: 8'd0};
			num_q[1] <= '{phase: gga_pkg::NP_LEAD, val: 8'd0};
		end else begin
			state_q <= state_d;
			if (clear) begin
				len_q    <= '0;
				fnum_q   <= '0;
				prefix_q <= 1'b0;
				zero_q   <= 1'b0;
				pend_q   <= 1'b0;
				tlen_q   <= '0;
				dir_q    <= '0;
				num_q[0] <= '{phase: gga_pkg::NP_LEAD, val: 8'd0};
				num_q[1] <= '{phase: gga_pkg::NP_LEAD, val: 8'd0};
			end else begin
				len_q    <= len_d;
				fnum_q   <= fnum_d;
				prefix_q <= prefix_d;
				zero_q   <= zero_d;
				pend_q   <= pend_d;
				tlen_q   <= tlen_d;
				dir_q    <= dir_d;
				num_q    <= num_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) byte_q <= in_ch.rx_byte;
	end

endmodule

/* design/gga_back.sv */
// Back end: holds the text memory and walks a matched line's fields:
// one item per cycle while the queue has room. Depends on gga_pkg.
module gga_back (
	input  logic              clk,
	input  logic              arst_n,
	input  gga_pkg::text_wr_t text_wr,
	input  gga_pkg::job_t     job,
	output logic              busy,
	output logic              push_valid,
	output gga_pkg::item_t    push_item,
	input  logic              push_ready
);

	logic [7:0] mem [gga_pkg::MEM_DEPTH];
	logic [7:0] rdata_q;

	gga_pkg::back_state_t state_q, state_d;
	gga_pkg::job_t        job_q;
	gga_pkg::field_code_t seg_q, seg_d;
	logic [gga_pkg::TLEN_W-1:0] idx_q, idx_d;

	logic                 valid_s1;
	gga_pkg::field_code_t code_s1;
	logic [7:0]           imm_s1;
	logic                 text_s1;
	logic                 last_s1;

	logic                 is_text;
	logic [1:0]           slot;
	logic [gga_pkg::TLEN_W-1:0] tl;
	logic                 empty_text;
	logic                 can_issue;
	logic                 issue;
	logic                 is_last;
	logic [7:0]           imm;

	// Segment decode
	always_comb begin
		is_text = 1'b0;
		slot    = 2'd0;
		imm     = 8'd0;
		unique case (seg_q)
			gga_pkg::FC_TIME: begin is_text = 1'b1; slot = 2'd0; end
			gga_pkg::FC_LAT:  begin is_text = 1'b1; slot = 2'd1; end
			gga_pkg::FC_LATD: imm = job_q.dirs[0];
			gga_pkg::FC_LON:  begin is_text = 1'b1; slot = 2'd2; end
			gga_pkg::FC_LOND: imm = job_q.dirs[1];
			gga_pkg::FC_FIX:  imm = job_q.nums[0];
			gga_pkg::FC_SATS: imm = job_q.nums[1];
			gga_pkg::FC_ALT:  begin is_text = 1'b1; slot = 2'd3; end
			default: ;
		endcase
		tl         = job_q.lens[slot];
		empty_text = is_text && (idx_q >= tl);
		can_issue  = !valid_s1 || push_ready;
		issue      = (state_q == gga_pkg::BS_RUN) && !empty_text && can_issue;
		is_last    = (seg_q == gga_pkg::FC_ALT && idx_q == tl - gga_pkg::TLEN_W'(1)) ||
			(seg_q == gga_pkg::FC_SATS && job_q.lens[3] == '0);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gga_pkg::BS_IDLE: if (job.start) state_d = gga_pkg::BS_RUN;
			gga_pkg::BS_RUN: begin
				if ((empty_text && seg_q == gga_pkg::FC_ALT) || (issue && is_last))
					state_d = gga_pkg::BS_IDLE;
			end
			default: state_d = gga_pkg::BS_IDLE;
		endcase
	end

	// Sequencer position
	always_comb begin
		seg_d = seg_q;
		idx_d = idx_q;
		if (state_q == gga_pkg::BS_IDLE) begin
			seg_d = gga_pkg::FC_TIME;
			idx_d = '0;
		end else if (empty_text || issue) begin
			if (issue && is_text && (idx_q + gga_pkg::TLEN_W'(1)) < tl) begin
				idx_d = idx_q + gga_pkg::TLEN_W'(1);
			end else begin
				seg_d = gga_pkg::field_code_t'(seg_q + 3'd1);
				idx_d = '0;
			end
		end
	end

	assign busy       = (state_q == gga_pkg::BS_RUN) || valid_s1;
	assign push_valid = valid_s1;
	assign push_item  = '{code: code_s1, value: text_s1 ? rdata_q : imm_s1, last: last_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= gga_pkg::BS_IDLE;
			seg_q    <= gga_pkg::FC_TIME;
			idx_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			seg_q   <= seg_d;
			idx_q   <= idx_d;
			if (issue) valid_s1 <= 1'b1;
			else if (push_ready) valid_s1 <= 1'b0;
		end
	end

	// Job snapshot and item stage payload
	always_ff @(posedge clk) begin
		if (state_q == gga_pkg::BS_IDLE && job.start) job_q <= job;
		if (issue) begin
			code_s1 <= seg_q;
			imm_s1  <= imm;
			text_s1 <= is_text;
			last_s1 <= is_last;
		end
	end

	// Text memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (text_wr.we) mem[text_wr.addr] <= text_wr.data;
		if (issue && is_text) rdata_q <= mem[gga_pkg::text_addr(slot, idx_q)];
	end

	// A job only arrives while the back end is free
	a_job_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job.start |-> !busy) else $error("job started while back end busy");

	// The front end never writes text while a run reads it
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !text_wr.we) else $error("text write during run");

	// A stalled item keeps its read data
	a_rdata_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !push_ready) |=> $stable(rdata_q)) else $error("read data lost");

	// The final item of a run ends the sequencer
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && is_last) |=> (state_q == gga_pkg::BS_IDLE)) else $error("run kept going");

endmodule

/* design/gga_ofifo.sv */
// Two-entry result queue between the back end and the output channel.
// Depends on gga_pkg and gga_item_if.
module gga_ofifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	input  gga_pkg::item_t push_item,
	output logic           push_ready,
	gga_item_if.source     out_ch
);

	gga_pkg::item_t ent_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;
	logic           push;
	logic           pop;

	assign push_ready = (cnt_q != 2'd2);
	assign push       = push_valid && push_ready;
	assign pop        = out_ch.valid && out_ch.ready;

	assign out_ch.valid      = (cnt_q != 2'd0);
	assign out_ch.field_code = ent_q[rd_q].code;
	assign out_ch.value      = ent_q[rd_q].value;
	assign out_ch.last       = ent_q[rd_q].last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop)  rd_q <= !rd_q;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= push_item;
	end

endmodule

/* design/gga_sentence_field_extractor.sv */
// GGA sentence field extractor: top level.
// Depends on gga_pkg, gga_ifs, gga_front, gga_back and gga_ofifo.
//
// Usage: bytes of a serial sentence stream enter on in_ch (rx_byte), one per
// transfer. Lines end at a newline; a line whose content opens with $GPGGA
// produces, on its newline, a run of result items on out_ch: time, latitude,
// latitude direction, longitude, longitude direction, fix, satellites and
// altitude, text one character per item, last marking the run's final item.
// Other lines give nothing.
// Byte flow: the front end accepts a byte while idle and works on it in its
// proc state before it takes the next, with a second proc pass when a held
// carriage return is folded back in as content. The newline is registered in
// the front end, which starts the job; the back end then issues one item per
// cycle while the output queue has room, from text memory and job snapshot,
// passing over each empty text field in a step of its own; in_ch holds ready
// low until the run has left the back end into the two-entry output queue.
// Reset: all line state clears at once; the text memory needs no clearing.
// Receiver stall: items wait in the output queue, then the back end pauses;
// no item is lost or repeated.
module gga_sentence_field_extractor (
	input  logic       clk,
	input  logic       arst_n,
	gga_byte_if.sink   in_ch,
	gga_item_if.source out_ch
);

	gga_pkg::text_wr_t text_wr;
	gga_pkg::job_t     job;
	logic              back_busy;
	logic              push_valid;
	logic              push_ready;
	gga_pkg::item_t    push_item;

	gga_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.back_busy (back_busy),
		.text_wr   (text_wr),
		.job       (job)
	);

	gga_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_wr    (text_wr),
		.job        (job),
		.busy       (back_busy),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready)
	);

	gga_ofifo u_ofifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready),
		.out_ch     (out_ch)
	);

endmodule
